FILE: rtl/rrft_pkg.sv
`timescale 1ns / 1ps

package rrft_pkg;

    // Width of the rules_held result field.
    localparam int HELD_W = 7;

    // Request action codes.
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ACCEPTED  = 3'd4,
        ST_REJECTED  = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    // One stored rule. End values are zero when the matching range flag is clear.
    typedef struct packed {
        logic [31:0] ip_start;
        logic [31:0] ip_end;
        logic        ip_ranged;
        logic [15:0] port_start;
        logic [15:0] port_end;
        logic        port_ranged;
    } rule_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_MOVE,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

FILE: rtl/range_rule_filter_table.sv
`timescale 1ns / 1ps

// Firewall rule table holding up to RULE_SLOTS rules of an IPv4 address or
// address range plus a port or port range. An add writes the rule in the start
// state and registers its result from the response state. A check or a
// well-formed delete walks the stored rules through the single registered read
// port of the rule memory, one rule per cycle; a delete that finds its rule then
// moves the last rule into the freed slot through the move and write states.
// The block takes one request at a time and is ready again in the cycle after a
// result is registered. A result waits in an output register, so the next
// request may be taken meanwhile.
module range_rule_filter_table
    import rrft_pkg::*;
#(
    parameter int RULE_SLOTS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [31:0]       ip_low,
    input  logic [31:0]       ip_high,
    input  logic              ip_is_range,
    input  logic [15:0]       port_low,
    input  logic [15:0]       port_high,
    input  logic              port_is_range,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [HELD_W-1:0] rules_held
);

    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam int ADDR_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]  del_idx_reg, del_idx_next;
    logic               out_valid_reg, out_valid_next;
    status_t            res_status_reg, res_status_next;
    status_t            status_reg, status_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    rule_t              req_rule_reg;
    logic [1:0]         req_action_reg;
    logic               req_ok_reg;

    rule_t              in_rule;
    logic               in_ok;
    logic               accept;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    rule_t              mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    rule_t              mem_rdata;
    logic               match;
    logic               hit;
    logic               miss;
    logic               issue;
    logic               out_free;

    // Normalise the incoming rule and check that any range has its high end above its low end.
    always_comb
    begin
        in_rule.ip_start    = ip_low;
        in_rule.ip_end      = ip_is_range ? ip_high : 32'd0;
        in_rule.ip_ranged   = ip_is_range;
        in_rule.port_start  = port_low;
        in_rule.port_end    = port_is_range ? port_high : 16'd0;
        in_rule.port_ranged = port_is_range;
        in_ok = (!ip_is_range || (ip_high > ip_low)) &&
                (!port_is_range || (port_high > port_low));
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_rule_reg   <= in_rule;
            req_action_reg <= action;
            req_ok_reg     <= in_ok;
        end
    end

    rrft_rule_mem #(
        .DEPTH  (RULE_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rrft_match_unit u_match (
        .is_check (req_action_reg == ACT_CHECK),
        .req      (req_rule_reg),
        .entry    (mem_rdata),
        .match    (match)
    );

    // Scan status: the read data belongs to the entry issued in the previous cycle.
    assign hit   = pend_reg && match;
    assign miss  = !hit && (scan_idx_reg == count_reg);
    assign issue = !hit && (scan_idx_reg < count_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if ((req_action_reg == ACT_CHECK) ||
                    ((req_action_reg == ACT_DELETE) && req_ok_reg))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (hit && (req_action_reg == ACT_DELETE))
                begin
                    state_next = S_MOVE;
                end
                else if (hit || miss)
                begin
                    state_next = S_RESP;
                end
            end
            S_MOVE:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and datapath logic of the sequencer.
    always_comb
    begin
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = req_rule_reg;
        mem_re          = 1'b0;
        mem_raddr       = scan_idx_reg[ADDR_W-1:0];
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        del_idx_next    = del_idx_reg;
        res_status_next = res_status_reg;
        status_next     = status_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_START:
            begin
                scan_idx_next   = '0;
                pend_next       = 1'b0;
                res_status_next = ST_INVALID;
                if (req_action_reg == ACT_ADD)
                begin
                    if (!req_ok_reg)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (count_reg >= CNT_W'(RULE_SLOTS))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = ST_ADDED;
                    end
                end
                else if (req_action_reg == ACT_CHECK)
                begin
                    res_status_next = ST_REJECTED;
                end
                else if (req_action_reg == ACT_DELETE)
                begin
                    res_status_next = req_ok_reg ? ST_NOT_FOUND : ST_INVALID;
                end
            end
            S_SCAN:
            begin
                mem_re        = issue;
                pend_next     = issue;
                cmp_idx_next  = scan_idx_reg[ADDR_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(issue);
                if (hit)
                begin
                    del_idx_next = cmp_idx_reg;
                    if (req_action_reg == ACT_CHECK)
                    begin
                        res_status_next = ST_ACCEPTED;
                    end
                end
            end
            S_MOVE:
            begin
                // Fetch the last stored rule to fill the freed slot.
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(count_reg - CNT_W'(1));
            end
            S_WRITE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = del_idx_reg;
                mem_wdata       = mem_rdata;
                count_next      = count_reg - CNT_W'(1);
                res_status_next = ST_DELETED;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    held_next      = HELD_W'(count_reg);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        del_idx_reg    <= del_idx_next;
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        held_reg       <= held_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign rules_held = held_reg;

`ifndef NO_ASSERTIONS
    // The rule count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RULE_SLOTS))
        else $error("rule count beyond table size");

    // The count changes only when an add or a delete completes.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_RESP))
        else $error("rule count changed outside a completing action");

    // A new result appears only from the response state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside the response state");
`endif

endmodule

FILE: rtl/rrft_rule_mem.sv
`timescale 1ns / 1ps

module rrft_rule_mem
    import rrft_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  rule_t             wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output rule_t             rdata
);

    rule_t mem [DEPTH];

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/rrft_match_unit.sv
`timescale 1ns / 1ps

module rrft_match_unit
    import rrft_pkg::*;
(
    input  logic  is_check,
    input  rule_t req,
    input  rule_t entry,
    output logic  match
);

    logic addr_hit;
    logic port_hit;

    // A check covers the address inclusively at both ends; the port range
    // excludes its start unless the port equals the start exactly.
    always_comb
    begin
        addr_hit = (req.ip_start == entry.ip_start) ||
                   (entry.ip_ranged && (req.ip_start >= entry.ip_start) &&
                    (req.ip_start <= entry.ip_end));
        port_hit = (req.port_start == entry.port_start) ||
                   (entry.port_ranged && (req.port_start > entry.port_start) &&
                    (req.port_start <= entry.port_end));
        if (is_check)
        begin
            match = addr_hit && port_hit;
        end
        else
        begin
            match = (req == entry);
        end
    end

endmodule
